// ----- rtl/uart_rm_pkg.sv -----
// Shared types and constants for the UART register model.
`default_nettype none

package uart_rm_pkg;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Register offsets
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    // Register bit masks
    localparam logic [7:0] LSR_RESET  = 8'h60;
    localparam logic [7:0] LSR_THRE   = 8'h60;
    localparam logic [7:0] LSR_DR     = 8'h01;
    localparam logic [7:0] IIR_NOPEND = 8'h01;
    localparam logic [7:0] IIR_TXE    = 8'h02;
    localparam logic [7:0] IIR_RX     = 8'h04;
    localparam logic [7:0] IER_RX     = 8'h01;
    localparam logic [7:0] IER_TX     = 8'h02;

    // One bus access or poll tick
    typedef struct packed {
        logic [1:0] command;
        logic [2:0] offset;
        logic [7:0] write_data;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       cpu_int_enable;
    } t_req;

    // Result of one request
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_raise;
        logic       irq_level;
    } t_rsp;

endpackage

`default_nettype wire

// ----- rtl/uart_rm_if.sv -----
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface uart_rm_req_if import uart_rm_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface uart_rm_rsp_if import uart_rm_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/uart_rm_regs.sv -----
// UART register file with its read, write and poll-tick update logic.
`default_nettype none

module uart_rm_regs import uart_rm_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_en,
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [7:0] r_data, r_ier, r_iir, r_lcr, r_mcr, r_lsr, r_msr, r_scr;
    logic       r_pending;
    logic [7:0] n_data, n_ier, n_iir, n_lcr, n_mcr, n_lsr, n_msr, n_scr;
    logic       n_pending;

    // Next register values and the result for the current request
    always_comb begin
        n_data    = r_data;
        n_ier     = r_ier;
        n_iir     = r_iir;
        n_lcr     = r_lcr;
        n_mcr     = r_mcr;
        n_lsr     = r_lsr;
        n_msr     = r_msr;
        n_scr     = r_scr;
        n_pending = r_pending;
        o_rsp     = '0;

        unique case (i_req.command)
            CMD_READ: begin
                unique case (i_req.offset)
                    REG_DATA: begin
                        // Receive read clears data-ready and the receive cause
                        n_pending = 1'b0;
                        n_iir     = (r_iir & ~IIR_RX) | IIR_NOPEND;
                        n_lsr     = r_lsr & ~LSR_DR;
                        o_rsp.read_data = r_data;
                    end
                    REG_IER: o_rsp.read_data = r_ier;
                    REG_IIR: o_rsp.read_data = r_iir;
                    REG_LCR: o_rsp.read_data = r_lcr;
                    REG_MCR: o_rsp.read_data = r_mcr;
                    REG_LSR: o_rsp.read_data = r_lsr;
                    REG_MSR: o_rsp.read_data = r_msr;
                    REG_SCR: o_rsp.read_data = r_scr;
                    default: o_rsp.read_data = r_scr;
                endcase
            end
            CMD_WRITE: begin
                unique case (i_req.offset)
                    REG_DATA: begin
                        // Transmit: byte goes out, transmit-empty drops
                        n_data    = i_req.write_data;
                        n_iir     = (r_iir & ~IIR_TXE) | IIR_NOPEND;
                        n_lsr     = r_lsr & ~LSR_THRE;
                        n_pending = 1'b0;
                        o_rsp.tx_valid = 1'b1;
                        o_rsp.tx_byte  = i_req.write_data;
                    end
                    REG_IER: n_ier = i_req.write_data;
                    REG_IIR: n_iir = i_req.write_data;
                    REG_LCR: n_lcr = i_req.write_data;
                    REG_MCR: n_mcr = i_req.write_data;
                    REG_LSR: n_lsr = i_req.write_data;
                    REG_MSR: n_msr = i_req.write_data;
                    REG_SCR: n_scr = i_req.write_data;
                    default: n_scr = i_req.write_data;
                endcase
            end
            CMD_TICK: begin
                // Ticks do nothing while an interrupt is pending
                if (!r_pending) begin
                    if (i_req.rx_valid) begin
                        n_data = i_req.rx_byte;
                        n_lsr  = n_lsr | LSR_DR;
                        n_iir  = n_iir | IIR_RX;
                    end
                    if (i_req.cpu_int_enable) begin
                        if (((r_ier & IER_RX) != '0) && ((n_iir & IIR_RX) != '0)) begin
                            n_iir     = n_iir & ~IIR_NOPEND;
                            n_pending = 1'b1;
                            o_rsp.irq_raise = 1'b1;
                        end
                        if ((r_ier & IER_TX) != '0) begin
                            n_iir     = (n_iir | IIR_TXE) & ~IIR_NOPEND;
                            n_lsr     = n_lsr | LSR_THRE;
                            n_pending = 1'b1;
                            o_rsp.irq_raise = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // unused command code: no state change
            end
        endcase

        o_rsp.irq_level = n_pending;
    end

    // State update when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data    <= '0;
            r_ier     <= '0;
            r_iir     <= '0;
            r_lcr     <= '0;
            r_mcr     <= '0;
            r_lsr     <= LSR_RESET;
            r_msr     <= '0;
            r_scr     <= '0;
            r_pending <= 1'b0;
        end else if (i_en) begin
            r_data    <= n_data;
            r_ier     <= n_ier;
            r_iir     <= n_iir;
            r_lcr     <= n_lcr;
            r_mcr     <= n_mcr;
            r_lsr     <= n_lsr;
            r_msr     <= n_msr;
            r_scr     <= n_scr;
            r_pending <= n_pending;
        end
    end

    // A transmit write always leaves the transmit-empty bits clear
    a_tx_clears_thre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_req.command == CMD_WRITE && i_req.offset == REG_DATA
        |=> (r_lsr & LSR_THRE) == '0 && !r_pending)
        else $error("transmit write left THRE or pending set");

    // A receive read drops data-ready and the pending interrupt
    a_rx_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_req.command == CMD_READ && i_req.offset == REG_DATA
        |=> (r_lsr & LSR_DR) == '0 && !r_pending)
        else $error("receive read left DR or pending set");

    // A tick while pending must not latch a received byte
    a_pending_blocks_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_req.command == CMD_TICK && r_pending |=> $stable(r_data))
        else $error("received byte latched while interrupt pending");

    // Only a tick can raise the pending interrupt
    a_pending_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !r_pending && n_pending |-> i_req.command == CMD_TICK)
        else $error("pending interrupt set by a non-tick request");

endmodule

`default_nettype wire

// ----- rtl/uart_register_model.sv -----
// Top level: request register, UART register file and result register.
// The block takes one request (register read, register write or poll tick) per
// cycle while the output side is ready and returns exactly one result per
// request, in order. A request waits in the input register, where the register
// file evaluates it and updates its state as the result is loaded into the
// output register; the result is then offered from there and is taken at an
// edge where the output side is ready. With the output side ready, the sustained
// rate is one request per cycle, set by the single register-file pass between
// the input and result registers; the input side keeps accepting while a
// finished result waits, until the input register too is full. Reset needs no
// clearing pass.
`default_nettype none

module uart_register_model import uart_rm_pkg::*; (
    input wire             i_clk,
    input wire             i_rst_n,
    uart_rm_req_if.sink    i_req,
    uart_rm_rsp_if.source  o_rsp
);

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    logic advance;
    t_rsp core_rsp;

    // Request moves on when the result register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
    end

    uart_rm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_req   (r_in),
        .o_rsp   (core_rsp)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Held request is never dropped while the result side stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("pending request lost");

    // A result is loaded only from a held request
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result produced without a request");

    // Stalled result stays put
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- bench/uart_register_model_tb.sv -----
// Self-checking testbench for the UART register model: directed and random requests.
`timescale 1ns / 100ps

module uart_register_model_tb;
    import uart_rm_pkg::*;

    // Command 3 has no function in the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned PHASE_REQUESTS = 200;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned CYCLE_LIMIT    = 100000;

    // Shadow copy of the UART registers plus the results it predicts
    class uart_reg_shadow;
        logic [7:0] data_q;
        logic [7:0] ier_q;
        logic [7:0] iir_q;
        logic [7:0] lcr_q;
        logic [7:0] mcr_q;
        logic [7:0] lsr_q;
        logic [7:0] msr_q;
        logic [7:0] scr_q;
        logic       irq_pending;
        t_rsp       expected_rsps[$];
        int unsigned mismatches;

        function new();
            data_q      = 8'h00;
            ier_q       = 8'h00;
            iir_q       = 8'h00;
            lcr_q       = 8'h00;
            mcr_q       = 8'h00;
            lsr_q       = LSR_RESET;
            msr_q       = 8'h00;
            scr_q       = 8'h00;
            irq_pending = 1'b0;
            mismatches  = 0;
        endfunction

        function int unsigned outstanding();
            return expected_rsps.size();
        endfunction

        // Update the shadow registers for one accepted request and queue its result
        function void note_request(t_req r);
            t_rsp exp_rsp;
            exp_rsp = '0;
            case (r.command)
                CMD_READ: begin
                    case (r.offset)
                        REG_DATA: begin
                            // reading the receive byte acknowledges the interrupt
                            irq_pending = 1'b0;
                            iir_q = (iir_q & ~IIR_RX) | IIR_NOPEND;
                            lsr_q = lsr_q & ~LSR_DR;
                            exp_rsp.read_data = data_q;
                        end
                        REG_IER: exp_rsp.read_data = ier_q;
                        REG_IIR: exp_rsp.read_data = iir_q;
                        REG_LCR: exp_rsp.read_data = lcr_q;
                        REG_MCR: exp_rsp.read_data = mcr_q;
                        REG_LSR: exp_rsp.read_data = lsr_q;
                        REG_MSR: exp_rsp.read_data = msr_q;
                        default: exp_rsp.read_data = scr_q;
                    endcase
                end
                CMD_WRITE: begin
                    case (r.offset)
                        REG_DATA: begin
                            // transmit shares the data register with receive
                            data_q = r.write_data;
                            iir_q = (iir_q & ~IIR_TXE) | IIR_NOPEND;
                            lsr_q = lsr_q & ~LSR_THRE;
                            irq_pending = 1'b0;
                            exp_rsp.tx_valid = 1'b1;
                            exp_rsp.tx_byte  = r.write_data;
                        end
                        REG_IER: ier_q = r.write_data;
                        REG_IIR: iir_q = r.write_data;
                        REG_LCR: lcr_q = r.write_data;
                        REG_MCR: mcr_q = r.write_data;
                        REG_LSR: lsr_q = r.write_data;
                        REG_MSR: msr_q = r.write_data;
                        default: scr_q = r.write_data;
                    endcase
                end
                CMD_TICK: begin
                    // a pending interrupt blocks the whole tick, offered byte is lost
                    if (!irq_pending) begin
                        if (r.rx_valid) begin
                            data_q = r.rx_byte;
                            lsr_q = lsr_q | LSR_DR;
                            iir_q = iir_q | IIR_RX;
                        end
                        if (r.cpu_int_enable) begin
                            if ((ier_q & IER_RX) != 0 && (iir_q & IIR_RX) != 0) begin
                                iir_q = iir_q & ~IIR_NOPEND;
                                irq_pending = 1'b1;
                                exp_rsp.irq_raise = 1'b1;
                            end
                            if ((ier_q & IER_TX) != 0) begin
                                iir_q = (iir_q | IIR_TXE) & ~IIR_NOPEND;
                                lsr_q = lsr_q | LSR_THRE;
                                irq_pending = 1'b1;
                                exp_rsp.irq_raise = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            exp_rsp.irq_level = irq_pending;
            expected_rsps.push_back(exp_rsp);
        endfunction

        // Compare one delivered result against the oldest prediction
        function void check_result(t_rsp got);
            t_rsp exp_rsp;
            if (expected_rsps.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                mismatches++;
                return;
            end
            exp_rsp = expected_rsps.pop_front();
            if (got.read_data !== exp_rsp.read_data) begin
                $error("read_data: expected %h, got %h", exp_rsp.read_data, got.read_data);
                mismatches++;
            end
            if (got.tx_valid !== exp_rsp.tx_valid) begin
                $error("tx_valid: expected %b, got %b", exp_rsp.tx_valid, got.tx_valid);
                mismatches++;
            end
            if (got.tx_byte !== exp_rsp.tx_byte) begin
                $error("tx_byte: expected %h, got %h", exp_rsp.tx_byte, got.tx_byte);
                mismatches++;
            end
            if (got.irq_raise !== exp_rsp.irq_raise) begin
                $error("irq_raise: expected %b, got %b", exp_rsp.irq_raise, got.irq_raise);
                mismatches++;
            end
            if (got.irq_level !== exp_rsp.irq_level) begin
                $error("irq_level: expected %b, got %b", exp_rsp.irq_level, got.irq_level);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    logic        hold_go = 1'b0;
    logic        rsp_hold = 1'b0;
    uart_reg_shadow uart_shadow;

    uart_rm_req_if req_if ();
    uart_rm_rsp_if rsp_if ();

    uart_register_model u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("uart_register_model regression: fail");
        $finish;
    end

    // Result side: check each accepted result, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            uart_shadow.check_result(rsp_if.payload);
        end
        if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    function automatic t_req make_request(logic [1:0] cmd, logic [2:0] off,
                                          logic [7:0] wdata, logic rxv,
                                          logic [7:0] rxb, logic cpu_en);
        t_req r;
        r.command        = cmd;
        r.offset         = off;
        r.write_data     = wdata;
        r.rx_valid       = rxv;
        r.rx_byte        = rxb;
        r.cpu_int_enable = cpu_en;
        return r;
    endfunction

    // Random request, weighted toward the interrupt path
    function automatic t_req random_request();
        t_req r;
        int unsigned pick;
        r.command        = CMD_READ;
        r.offset         = 3'($urandom_range(7));
        r.write_data     = 8'($urandom);
        r.rx_valid       = 1'($urandom_range(1));
        r.rx_byte        = 8'($urandom);
        r.cpu_int_enable = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 35) begin
            r.command = CMD_READ;
            if ($urandom_range(1) == 1) begin
                case ($urandom_range(2))
                    0:       r.offset = REG_DATA;
                    1:       r.offset = REG_IIR;
                    default: r.offset = REG_LSR;
                endcase
            end
        end else if (pick < 65) begin
            r.command = CMD_WRITE;
            case ($urandom_range(3))
                0: begin
                    // mostly flip the two enables, keep other bits random sometimes
                    r.offset = REG_IER;
                    if ($urandom_range(3) != 0) r.write_data = 8'($urandom_range(3));
                end
                1:       r.offset = REG_DATA;
                default: ;
            endcase
        end else if (pick < 95) begin
            r.command = CMD_TICK;
            r.cpu_int_enable = ($urandom_range(9) < 7);
        end else begin
            r.command = CMD_UNUSED;
        end
        return r;
    endfunction

    // Offer one request, idling first at the current rate, and wait for acceptance
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        uart_shadow.note_request(r);
    endtask

    initial begin
        uart_shadow    = new();
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of every register
        for (int off = 0; off < 8; off++) begin
            send_request(make_request(CMD_READ, 3'(off), 8'h00, 1'b0, 8'h00, 1'b0));
        end
        // Scratch reads back the scratch value, not LCR
        send_request(make_request(CMD_WRITE, REG_SCR, 8'hFF, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_WRITE, REG_LCR, 8'h00, 1'b1, 8'hFF, 1'b1));
        send_request(make_request(CMD_READ, REG_SCR, 8'h00, 1'b0, 8'h00, 1'b0));
        // Both causes on one tick, then a tick while pending drops its byte
        send_request(make_request(CMD_WRITE, REG_IER, 8'h03, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_TICK, REG_DATA, 8'h00, 1'b1, 8'hFF, 1'b1));
        send_request(make_request(CMD_TICK, REG_DATA, 8'h00, 1'b1, 8'h5A, 1'b1));
        send_request(make_request(CMD_READ, REG_IIR, 8'h00, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_READ, REG_LSR, 8'h00, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_READ, REG_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
        // Transmit overwrites the receive byte
        send_request(make_request(CMD_WRITE, REG_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_WRITE, REG_DATA, 8'hFF, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_READ, REG_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
        // Unused command, ticks with enable off and with IER cleared
        send_request(make_request(CMD_UNUSED, REG_SCR, 8'hFF, 1'b1, 8'hFF, 1'b1));
        send_request(make_request(CMD_TICK, REG_DATA, 8'h00, 1'b1, 8'h00, 1'b0));
        send_request(make_request(CMD_WRITE, REG_IER, 8'h00, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_TICK, REG_DATA, 8'h00, 1'b1, 8'hA5, 1'b1));
        // Plain stores to IIR, LSR, MSR and MCR; MSR is read back
        send_request(make_request(CMD_WRITE, REG_IIR, 8'hFF, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_WRITE, REG_LSR, 8'hFF, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_WRITE, REG_MSR, 8'hAA, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_WRITE, REG_MCR, 8'h55, 1'b0, 8'h00, 1'b0));
        send_request(make_request(CMD_READ, REG_MSR, 8'h00, 1'b0, 8'h00, 1'b0));

        // Random phases: sender mostly busy, then receiver mostly busy, then no idling
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 9;
                    sink_idle_pct <= 46;
                end
                1: begin
                    src_idle_pct = 46;
                    sink_idle_pct <= 9;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct <= 0;
                    hold_go <= 1'b1;
                end
            endcase
            repeat (PHASE_REQUESTS) send_request(random_request());
        end
        req_if.valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        while (uart_shadow.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (uart_shadow.mismatches == 0 && uart_shadow.outstanding() == 0) begin
            $display("uart_register_model regression: pass");
        end else begin
            $display("uart_register_model regression: fail");
        end
        $finish;
    end

endmodule

// ----- uart_register_model.f -----
rtl/uart_rm_pkg.sv
rtl/uart_rm_if.sv
rtl/uart_rm_regs.sv
rtl/uart_register_model.sv
bench/uart_register_model_tb.sv
